@@ design/sts_pkg.sv @@
// Package for the scheduled thermostat sequencer: payload struct types.
`timescale 1ns / 1ps

package sts_pkg;

    // One input item: a process step or a mode change
    typedef struct packed {
        logic        kind;
        logic        set_auto;
        logic [31:0] now_us;
        logic        claim_granted;
        logic        request_accepted;
        logic        result_ready;
        logic [7:0]  read_byte;
        logic [2:0]  day_of_week;
        logic [4:0]  hour_of_day;
        logic [15:0] sensor_value;
    } in_item_t;

    // One result item: bus requests of this step and the heater drive
    typedef struct packed {
        logic [1:0] claim_target;
        logic [1:0] read_target;
        logic [7:0] read_page;
        logic [7:0] read_address;
        logic [1:0] release_target;
        logic       heater_on;
    } out_item_t;

endpackage

@@ design/scheduled_thermostat_sequencer_unit.sv @@
// Top level of the scheduled thermostat sequencer: phase sequencer, timers, hysteresis.
`timescale 1ns / 1ps

//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_data (in_item_t)    | in
//  result  | m_valid, m_ready, m_data (out_item_t)   | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  One item per cycle while the result is not stalled: input register, then the
//  phase logic with one 16x17 reciprocal multiply, then the result register.
//  Reset sets the phase, sequencer state, valid flags and config to reset values.
//  A stalled result holds in the result register; one more item waits in the
//  input register, after which s_ready follows m_ready.
//  Config writes are taken in every cycle.

module scheduled_thermostat_sequencer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sts_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sts_pkg::*;

    // Phase codes
    localparam logic [3:0] PH_MODE     = 4'd0;
    localparam logic [3:0] PH_MODE_RES = 4'd1;
    localparam logic [3:0] PH_DT       = 4'd2;
    localparam logic [3:0] PH_DT_RES   = 4'd3;
    localparam logic [3:0] PH_TEMP     = 4'd4;
    localparam logic [3:0] PH_TEMP_RES = 4'd5;
    localparam logic [3:0] PH_MIN      = 4'd6;
    localparam logic [3:0] PH_MIN_RES  = 4'd7;
    localparam logic [3:0] PH_MAX      = 4'd8;
    localparam logic [3:0] PH_MAX_RES  = 4'd9;
    localparam logic [3:0] PH_IDLE     = 4'd10;

    // Claim / release and read target codes
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_MEM  = 2'd1;
    localparam logic [1:0] TGT_CLK  = 2'd2;
    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_MEM   = 2'd1;
    localparam logic [1:0] RD_DT    = 2'd2;
    localparam logic [1:0] RD_TEMP  = 2'd3;

    // Config register indexes
    localparam logic [2:0] REG_MODE_LOC   = 3'd0;
    localparam logic [2:0] REG_MAN_MIN    = 3'd1;
    localparam logic [2:0] REG_MAN_MAX    = 3'd2;
    localparam logic [2:0] REG_AUTO_MIN   = 3'd3;
    localparam logic [2:0] REG_AUTO_MAX   = 3'd4;
    localparam logic [2:0] REG_CLK_IVL    = 3'd5;
    localparam logic [2:0] REG_TEMP_IVL   = 3'd6;

    localparam logic [31:0] CLK_IVL_RESET  = 32'd60000000;
    localparam logic [31:0] TEMP_IVL_RESET = 32'd1000000;

    // temp / 100 as (temp * ceil(2^23 / 100)) >> 23, exact for 16-bit temp
    localparam int          DIV_SHIFT = 23;
    localparam logic [32:0] DIV_MUL   = 33'd83887;

    // Configuration registers
    logic [15:0] mode_loc_reg;
    logic [15:0] man_min_loc_reg;
    logic [15:0] man_max_loc_reg;
    logic [7:0]  auto_min_page_reg;
    logic [7:0]  auto_max_page_reg;
    logic [31:0] clk_ivl_reg;
    logic [31:0] temp_ivl_reg;

    // Sequencer state
    logic [3:0]  phase_reg,      phase_next;
    logic        auto_mode_reg,  auto_mode_next;
    logic [2:0]  day_reg,        day_next;
    logic [4:0]  hour_reg,       hour_next;
    logic [15:0] temp_reg,       temp_next;
    logic [7:0]  low_thr_reg,    low_thr_next;
    logic [7:0]  high_thr_reg,   high_thr_next;
    logic [31:0] last_clk_reg,   last_clk_next;
    logic [31:0] last_temp_reg,  last_temp_next;
    logic        heating_reg,    heating_next;

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    out_item_t result;
    logic      advance;

    // Datapath helpers
    logic [7:0]  sched_addr;
    logic [15:0] loc;
    logic [31:0] clk_diff;
    logic [31:0] temp_diff;
    logic [32:0] temp_prod;
    logic [9:0]  temp_whole;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_loc_reg      <= '0;
            man_min_loc_reg   <= '0;
            man_max_loc_reg   <= '0;
            auto_min_page_reg <= '0;
            auto_max_page_reg <= '0;
            clk_ivl_reg       <= CLK_IVL_RESET;
            temp_ivl_reg      <= TEMP_IVL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MODE_LOC: mode_loc_reg      <= cfg_data[15:0];
                REG_MAN_MIN:  man_min_loc_reg   <= cfg_data[15:0];
                REG_MAN_MAX:  man_max_loc_reg   <= cfg_data[15:0];
                REG_AUTO_MIN: auto_min_page_reg <= cfg_data[7:0];
                REG_AUTO_MAX: auto_max_page_reg <= cfg_data[7:0];
                REG_CLK_IVL:  clk_ivl_reg       <= cfg_data;
                REG_TEMP_IVL: temp_ivl_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Schedule address 24*day+hour, low 8 bits; timer differences wrap
    assign sched_addr = {1'b0, day_reg, 4'b0000} + {2'b00, day_reg, 3'b000}
                      + {3'b000, hour_reg};
    assign clk_diff   = in_data_reg.now_us - last_clk_reg;
    assign temp_diff  = in_data_reg.now_us - last_temp_reg;

    // Phase step
    always_comb begin
        phase_next     = phase_reg;
        auto_mode_next = auto_mode_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        temp_next      = temp_reg;
        low_thr_next   = low_thr_reg;
        high_thr_next  = high_thr_reg;
        last_clk_next  = last_clk_reg;
        last_temp_next = last_temp_reg;
        loc            = '0;
        result         = '0;

        if (in_data_reg.kind) begin
            auto_mode_next = in_data_reg.set_auto;
            phase_next     = PH_MIN;
        end else begin
            unique case (phase_reg)
                PH_MODE, PH_MIN, PH_MAX: begin
                    result.claim_target = TGT_MEM;
                    if (in_data_reg.claim_granted) begin
                        result.read_target = RD_MEM;
                        if (phase_reg == PH_MODE) begin
                            loc = mode_loc_reg;
                        end else if (auto_mode_reg) begin
                            loc = {(phase_reg == PH_MAX) ? auto_max_page_reg
                                                         : auto_min_page_reg,
                                   sched_addr};
                        end else begin
                            loc = (phase_reg == PH_MAX) ? man_max_loc_reg
                                                        : man_min_loc_reg;
                        end
                        if (in_data_reg.request_accepted) begin
                            phase_next = phase_reg + 4'd1;
                        end else begin
                            result.release_target = TGT_MEM;
                        end
                    end
                end
                PH_MODE_RES: begin
                    if (in_data_reg.result_ready) begin
                        auto_mode_next        = in_data_reg.read_byte != 8'd0;
                        result.release_target = TGT_MEM;
                        phase_next            = PH_DT;
                    end
                end
                PH_DT: begin
                    result.claim_target = TGT_CLK;
                    if (in_data_reg.claim_granted) begin
                        result.read_target = RD_DT;
                        if (in_data_reg.request_accepted) begin
                            phase_next = PH_DT_RES;
                        end else begin
                            result.release_target = TGT_CLK;
                        end
                    end
                end
                PH_DT_RES: begin
                    if (in_data_reg.result_ready) begin
                        day_next              = in_data_reg.day_of_week;
                        hour_next             = in_data_reg.hour_of_day;
                        result.release_target = TGT_CLK;
                        phase_next            = PH_TEMP;
                    end
                end
                PH_TEMP: begin
                    result.read_target = RD_TEMP;
                    if (in_data_reg.request_accepted) begin
                        phase_next = PH_TEMP_RES;
                    end
                end
                PH_TEMP_RES: begin
                    if (in_data_reg.result_ready) begin
                        temp_next  = in_data_reg.sensor_value;
                        phase_next = PH_MIN;
                    end
                end
                PH_MIN_RES: begin
                    if (in_data_reg.result_ready) begin
                        low_thr_next          = in_data_reg.read_byte;
                        result.release_target = TGT_MEM;
                        phase_next            = PH_MAX;
                    end
                end
                PH_MAX_RES: begin
                    if (in_data_reg.result_ready) begin
                        high_thr_next         = in_data_reg.read_byte;
                        result.release_target = TGT_MEM;
                        phase_next            = PH_IDLE;
                    end
                end
                default: begin
                    // idle, and any unused code: wait on the refresh timers
                    if (clk_diff > clk_ivl_reg) begin
                        phase_next     = PH_DT;
                        last_clk_next  = in_data_reg.now_us;
                        last_temp_next = in_data_reg.now_us;
                    end else if (temp_diff > temp_ivl_reg) begin
                        phase_next     = PH_TEMP;
                        last_temp_next = in_data_reg.now_us;
                    end
                end
            endcase
        end

        result.read_page    = loc[15:8];
        result.read_address = loc[7:0];
    end

    // Hysteresis on whole degrees, using this step's temperature and thresholds
    assign temp_prod  = {17'd0, temp_next} * DIV_MUL;
    assign temp_whole = temp_prod[DIV_SHIFT +: 10];

    always_comb begin
        heating_next = heating_reg;
        if (!in_data_reg.kind) begin
            priority if (heating_reg && temp_whole >= {2'b00, high_thr_next}) begin
                heating_next = 1'b0;
            end else if (temp_whole < {2'b00, low_thr_next}) begin
                heating_next = 1'b1;
            end else begin
                heating_next = heating_reg;
            end
        end
    end

    // Result word with the updated heater drive
    always_comb begin
        out_data_next           = result;
        out_data_next.heater_on = heating_next;
    end

    // Input register: takes a transfer while the stage is empty or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Sequencer state commits when an item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_MODE;
            auto_mode_reg <= 1'b0;
            day_reg       <= '0;
            hour_reg      <= '0;
            temp_reg      <= '0;
            low_thr_reg   <= '0;
            high_thr_reg  <= '0;
            last_clk_reg  <= '0;
            last_temp_reg <= '0;
            heating_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            auto_mode_reg <= auto_mode_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            temp_reg      <= temp_next;
            low_thr_reg   <= low_thr_next;
            high_thr_reg  <= high_thr_next;
            last_clk_reg  <= last_clk_next;
            last_temp_reg <= last_temp_next;
            heating_reg   <= heating_next;
        end
    end

    // A mode change issues no claim, read or release
    a_mode_change_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.kind |=>
            m_data.claim_target == TGT_NONE && m_data.read_target == RD_NONE &&
            m_data.release_target == TGT_NONE)
        else $error("mode change produced a bus request");

    // Page and address only accompany a memory byte read
    a_loc_only_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_target != RD_MEM |->
            m_data.read_page == 8'd0 && m_data.read_address == 8'd0)
        else $error("read location without memory read");

    // Memory and date-time reads are only issued under a claim of the same device
    a_read_under_claim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.read_target == RD_MEM || m_data.read_target == RD_DT) |->
            m_data.claim_target != TGT_NONE)
        else $error("read issued without a claim");

    // Heater output matches the committed heating state
    a_heater_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_data.heater_on == heating_reg)
        else $error("heater output disagrees with state");

    // The sequencer never reaches an unused phase code
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> phase_reg <= PH_IDLE)
        else $error("phase left the sequence");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the thermostat sequencer: directed and random steps checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import sts_pkg::*;

    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int RANDOM_PHASES   = 6;
    localparam int LONG_HOLD       = 80;
    localparam int SLOTS_PER_DAY   = 24;
    localparam int CENTI           = 100;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_MODE, PH_MODE_RES, PH_DT, PH_DT_RES, PH_TEMP, PH_TEMP_RES,
        PH_MIN, PH_MIN_RES, PH_MAX, PH_MAX_RES, PH_IDLE
    } phase_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE_LOC, REG_MAN_MIN_LOC, REG_MAN_MAX_LOC, REG_AUTO_MIN_PAGE,
        REG_AUTO_MAX_PAGE, REG_CLK_INTERVAL, REG_TEMP_INTERVAL
    } reg_idx_t;

    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_MEM  = 2'd1;
    localparam logic [1:0] TGT_CLK  = 2'd2;
    localparam logic [1:0] RD_MEM   = 2'd1;
    localparam logic [1:0] RD_DT    = 2'd2;
    localparam logic [1:0] RD_TEMP  = 2'd3;
    localparam logic KIND_STEP     = 1'b0;
    localparam logic KIND_SET_MODE = 1'b1;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // stimulus and scoreboard
    in_item_t    pending_steps[$];
    out_item_t   awaited_cmds[$];
    logic [31:0] stim_now    = '0;
    bit          steady_flow = 1'b0;
    int          hold_reqs   = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          mismatches  = 0;
    int          cycle_count = 0;

    // predicted registers
    logic [15:0] mode_loc_q      = '0;
    logic [15:0] man_min_loc_q   = '0;
    logic [15:0] man_max_loc_q   = '0;
    logic [7:0]  auto_min_pg_q   = '0;
    logic [7:0]  auto_max_pg_q   = '0;
    logic [31:0] clk_intv_q      = 32'd60000000;
    logic [31:0] temp_intv_q     = 32'd1000000;

    // predicted sequencer state
    phase_t      ph_q            = PH_MODE;
    logic        auto_q          = 1'b0;
    logic        heat_q          = 1'b0;
    logic [2:0]  day_q           = '0;
    logic [4:0]  hour_q          = '0;
    logic [15:0] temp_q          = '0;
    logic [7:0]  lo_thr_q        = '0;
    logic [7:0]  hi_thr_q        = '0;
    logic [31:0] last_clk_q      = '0;
    logic [31:0] last_temp_q     = '0;

    scheduled_thermostat_sequencer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #5 aclk = ~aclk;

    // threshold byte location: schedule slot in auto mode, fixed location in manual
    function automatic logic [15:0] threshold_loc(input logic want_max);
        logic [31:0] slot;
        slot = SLOTS_PER_DAY * day_q + hour_q;
        if (!auto_q)
            return want_max ? man_max_loc_q : man_min_loc_q;
        return {want_max ? auto_max_pg_q : auto_min_pg_q, slot[7:0]};
    endfunction

    // advance the predicted sequencer by one item and return its bus commands
    function automatic out_item_t sequencer_step(input in_item_t it);
        out_item_t   r;
        logic [15:0] loc;
        logic [31:0] whole;
        logic [31:0] since_clk;
        logic [31:0] since_temp;
        r = '0;
        loc = '0;
        if (it.kind == KIND_SET_MODE) begin
            // mode change: no bus traffic, heater shown without update
            auto_q = it.set_auto;
            ph_q = PH_MIN;
        end else begin
            case (ph_q)
                PH_MODE, PH_MIN, PH_MAX: begin
                    r.claim_target = TGT_MEM;
                    if (it.claim_granted) begin
                        r.read_target = RD_MEM;
                        loc = (ph_q == PH_MODE) ? mode_loc_q : threshold_loc(ph_q == PH_MAX);
                        if (it.request_accepted)
                            ph_q = phase_t'(ph_q + 4'd1);
                        else
                            r.release_target = TGT_MEM;
                    end
                end
                PH_MODE_RES: begin
                    if (it.result_ready) begin
                        auto_q = (it.read_byte != 8'd0);
                        r.release_target = TGT_MEM;
                        ph_q = PH_DT;
                    end
                end
                PH_DT: begin
                    r.claim_target = TGT_CLK;
                    if (it.claim_granted) begin
                        r.read_target = RD_DT;
                        if (it.request_accepted)
                            ph_q = PH_DT_RES;
                        else
                            r.release_target = TGT_CLK;
                    end
                end
                PH_DT_RES: begin
                    if (it.result_ready) begin
                        day_q = it.day_of_week;
                        hour_q = it.hour_of_day;
                        r.release_target = TGT_CLK;
                        ph_q = PH_TEMP;
                    end
                end
                PH_TEMP: begin
                    r.read_target = RD_TEMP;
                    if (it.request_accepted)
                        ph_q = PH_TEMP_RES;
                end
                PH_TEMP_RES: begin
                    if (it.result_ready) begin
                        temp_q = it.sensor_value;
                        ph_q = PH_MIN;
                    end
                end
                PH_MIN_RES: begin
                    if (it.result_ready) begin
                        lo_thr_q = it.read_byte;
                        r.release_target = TGT_MEM;
                        ph_q = PH_MAX;
                    end
                end
                PH_MAX_RES: begin
                    if (it.result_ready) begin
                        hi_thr_q = it.read_byte;
                        r.release_target = TGT_MEM;
                        ph_q = PH_IDLE;
                    end
                end
                default: begin
                    // idle: wrapping elapsed time, clock refresh has priority
                    since_clk = it.now_us - last_clk_q;
                    since_temp = it.now_us - last_temp_q;
                    if (since_clk > clk_intv_q) begin
                        ph_q = PH_DT;
                        last_clk_q = it.now_us;
                        last_temp_q = it.now_us;
                    end else if (since_temp > temp_intv_q) begin
                        ph_q = PH_TEMP;
                        last_temp_q = it.now_us;
                    end
                end
            endcase
            // hysteresis on whole degrees
            whole = temp_q / CENTI;
            if (heat_q && whole >= hi_thr_q)
                heat_q = 1'b0;
            else if (whole < lo_thr_q)
                heat_q = 1'b1;
        end
        r.read_page = loc[15:8];
        r.read_address = loc[7:0];
        r.heater_on = heat_q;
        return r;
    endfunction

    function automatic in_item_t mk_step(input logic [31:0] now, input int grant,
                                         input int accept, input int rdy,
                                         input int rbyte, input int day,
                                         input int hour, input int sensor);
        in_item_t it;
        it.kind = KIND_STEP;
        it.set_auto = 1'($urandom_range(0, 1));
        it.now_us = now;
        it.claim_granted = 1'(grant);
        it.request_accepted = 1'(accept);
        it.result_ready = 1'(rdy);
        it.read_byte = 8'(rbyte);
        it.day_of_week = 3'(day);
        it.hour_of_day = 5'(hour);
        it.sensor_value = 16'(sensor);
        return it;
    endfunction

    function automatic in_item_t mk_mode(input logic auto_sel, input logic [31:0] now);
        in_item_t it;
        it = mk_step(now, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 255), $urandom_range(0, 6), $urandom_range(0, 23),
                     $urandom_range(0, 65535));
        it.kind = KIND_SET_MODE;
        it.set_auto = auto_sel;
        return it;
    endfunction

    // random step: mostly cooperative peripherals so the sequence moves on
    function automatic in_item_t random_step();
        in_item_t    it;
        int          rbyte;
        int          sensor;
        if ($urandom_range(0, 99) < 3)
            stim_now = $urandom();
        else
            stim_now = stim_now + $urandom_range(0, 20);
        rbyte = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
        sensor = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 25599);
        it = mk_step(stim_now, int'($urandom_range(0, 99) < 85),
                     int'($urandom_range(0, 99) < 85),
                     int'($urandom_range(0, 99) < 75), rbyte, $urandom_range(0, 6),
                     $urandom_range(0, 23), sensor);
        if ($urandom_range(0, 99) < 4) begin
            it.kind = KIND_SET_MODE;
        end
        return it;
    endfunction

    // one register write; caller lowers cfg_valid after the last one
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MODE_LOC:      mode_loc_q = val[15:0];
            REG_MAN_MIN_LOC:   man_min_loc_q = val[15:0];
            REG_MAN_MAX_LOC:   man_max_loc_q = val[15:0];
            REG_AUTO_MIN_PAGE: auto_min_pg_q = val[7:0];
            REG_AUTO_MAX_PAGE: auto_max_pg_q = val[7:0];
            REG_CLK_INTERVAL:  clk_intv_q = val;
            REG_TEMP_INTERVAL: temp_intv_q = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_steps.size() != 0 || s_valid || awaited_cmds.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // input driver: one transfer per accepted handshake, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                awaited_cmds.push_back(sequencer_step(s_data));
            if (!s_valid || s_ready) begin
                if (pending_steps.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= 31)) begin
                    s_data <= pending_steps.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin : result_monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_cmds.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, m_data);
                end else begin
                    want = awaited_cmds.pop_front();
                    check_field("claim_target", 32'(want.claim_target),
                                32'(m_data.claim_target));
                    check_field("read_target", 32'(want.read_target),
                                32'(m_data.read_target));
                    check_field("read_page", 32'(want.read_page), 32'(m_data.read_page));
                    check_field("read_address", 32'(want.read_address),
                                32'(m_data.read_address));
                    check_field("release_target", 32'(want.release_target),
                                32'(m_data.release_target));
                    check_field("heater_on", 32'(want.heater_on), 32'(m_data.heater_on));
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_seen != hold_reqs) begin
                hold_seen <= hold_reqs;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_flow || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("FAIL scheduled_thermostat_sequencer_unit");
            $finish;
        end
    end

    initial begin
        logic [31:0] reg_vals [7];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed walk through the whole sequence with reset registers
        pending_steps.push_back(mk_step(10, 0, 0, 0, 0, 0, 0, 0));       // claim refused
        pending_steps.push_back(mk_step(20, 1, 0, 0, 0, 0, 0, 0));       // read refused
        pending_steps.push_back(mk_step(30, 1, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(40, 1, 1, 0, 0, 0, 0, 0));       // not ready
        pending_steps.push_back(mk_step(50, 0, 0, 1, 255, 0, 0, 0));     // auto mode
        pending_steps.push_back(mk_step(60, 0, 0, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(70, 1, 0, 0, 0, 0, 0, 0));       // clock released
        pending_steps.push_back(mk_step(80, 1, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(90, 0, 0, 1, 0, 6, 23, 0));
        pending_steps.push_back(mk_step(100, 0, 0, 0, 0, 0, 0, 65535));
        pending_steps.push_back(mk_step(110, 0, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(120, 0, 0, 1, 0, 0, 0, 0));      // temp 0
        pending_steps.push_back(mk_step(130, 1, 1, 0, 0, 0, 0, 0));      // slot 167
        pending_steps.push_back(mk_step(140, 0, 0, 1, 255, 0, 0, 0));    // heat on
        pending_steps.push_back(mk_step(150, 1, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(160, 0, 0, 1, 0, 0, 0, 0));      // heat off
        pending_steps.push_back(mk_step(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_mode(1'b0, 0));                       // manual
        pending_steps.push_back(mk_step(5, 1, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(6, 0, 0, 1, 0, 0, 0, 0));
        pending_steps.push_back(mk_mode(1'b1, 32'hFFFF_FFFF));           // auto again
        pending_steps.push_back(mk_step(7, 1, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(8, 0, 0, 1, 200, 0, 0, 0));
        pending_steps.push_back(mk_step(9, 1, 1, 0, 0, 0, 0, 0));
        pending_steps.push_back(mk_step(10, 0, 0, 1, 255, 0, 0, 0));
        stim_now = 32'd10;

        // random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            @(posedge aclk);
            for (int i = 0; i < 7; i++) begin
                if (p == 1)
                    reg_vals[i] = 32'h0;
                else if (p == 2)
                    reg_vals[i] = 32'hFFFF_FFFF;
                else
                    reg_vals[i] = $urandom();
            end
            if (p != 1 && p != 2) begin
                reg_vals[REG_CLK_INTERVAL] = $urandom_range(20, 200);
                reg_vals[REG_TEMP_INTERVAL] = $urandom_range(0, 40);
            end
            for (int i = 0; i < 7; i++)
                write_reg(reg_idx_t'(i), reg_vals[i]);
            cfg_valid <= 1'b0;
            @(negedge aclk);
            steady_flow = (p == 3 || p == 4);
            if (p == 4)
                hold_reqs++;
            repeat (ITEMS_PER_PHASE) pending_steps.push_back(random_step());
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS scheduled_thermostat_sequencer_unit");
        else
            $display("FAIL scheduled_thermostat_sequencer_unit");
        $finish;
    end

endmodule
